/* rtl/three_stacks_shared_store_top_assert.svh */
// Assertion macros shared by the three-stack store modules.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef THREE_STACKS_SHARED_STORE_TOP_ASSERT_SVH
`define THREE_STACKS_SHARED_STORE_TOP_ASSERT_SVH

// Same-cycle implication, ignored while reset is held.
`define TSS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("three stacks store: same-cycle check failed");

// Next-cycle implication, ignored while reset is held.
`define TSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("three stacks store: next-cycle check failed");

`endif

/* rtl/tss_pkg.sv */
// Shared constants, codes and controller/datapath types for the three-stack store.
// No dependencies.
`timescale 1ns / 1ps

package tss_pkg;

  // Default geometry.
  localparam int DEPTH_DEF      = 256;
  localparam int NUM_STACKS_DEF = 3;

  // Field widths.
  localparam int OP_W      = 2;
  localparam int SEL_W     = 2;
  localparam int VALUE_W   = 32;
  localparam int STATUS_W  = 2;
  localparam int DATA_W    = 32;
  localparam int COUNT_W   = 9;
  localparam int CAP_W     = 9;
  localparam int IN_USER_W = OP_W + SEL_W;
  localparam int OUT_DATA_RAW_W = DATA_W + COUNT_W;
  localparam int OUT_TDATA_W    = ((OUT_DATA_RAW_W + 7) / 8) * 8;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP  = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK = 2'd2;
  localparam logic [OP_W-1:0] OP_SIZE = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the incoming request
    logic exec;      // commit the latched request and load the result stage
  } tss_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // result stage is empty or is being emptied this cycle
  } tss_stat_t;

endpackage

/* rtl/tss_ctrl.sv */
// Controller state machine for the three-stack store: sequences accept and execute.
// Depends on tss_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "three_stacks_shared_store_top_assert.svh"

module tss_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  tss_pkg::tss_stat_t stat,
  output tss_pkg::tss_cmd_t  cmd
);
  import tss_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r;
  logic state_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        // Commit only once the result stage can take the answer.
        if (stat.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A request waits in execute while the result stage stays full.
  `TSS_ASSERT_NEXT(a_exec_waits, (state_r == S_EXEC) && !stat.out_free, state_r == S_EXEC)
  // Every accepted transaction is followed by its execute step.
  `TSS_ASSERT_NEXT(a_accept_to_exec, in_tvalid && in_tready, state_r == S_EXEC)

endmodule

/* rtl/tss_dp.sv */
// Datapath for the three-stack store: request latch, counts, element memory,
// capacity register and result stage. Depends on tss_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "three_stacks_shared_store_top_assert.svh"

module tss_dp #(
  parameter int DEPTH      = tss_pkg::DEPTH_DEF,
  parameter int NUM_STACKS = tss_pkg::NUM_STACKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tss_pkg::tss_cmd_t             cmd,
  output tss_pkg::tss_stat_t            stat,
  input  logic [tss_pkg::OP_W-1:0]      req_op,
  input  logic [tss_pkg::SEL_W-1:0]     req_sel,
  input  logic [tss_pkg::VALUE_W-1:0]   req_value,
  input  logic                          cfg_wr,
  input  logic [tss_pkg::CAP_W-1:0]     cfg_cap,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [tss_pkg::STATUS_W-1:0]  out_status,
  output logic [tss_pkg::DATA_W-1:0]    out_data,
  output logic [tss_pkg::COUNT_W-1:0]   out_count
);
  import tss_pkg::*;

  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int IDX_W   = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int ENTRIES = NUM_STACKS * DEPTH;
  localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Latched request.
  logic [OP_W-1:0]    op_r;
  logic [SEL_W-1:0]   sel_r;
  logic [VALUE_W-1:0] val_r;

  // Architectural state.
  logic [CAP_W-1:0] cap_r;
  logic [CNT_W-1:0] cnt_r [NUM_STACKS];
  logic [DATA_W-1:0] mem [ENTRIES];

  // Result stage.
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [DATA_W-1:0]   out_data_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic                out_from_mem_r;
  logic [DATA_W-1:0]   rd_data_r;

  // Decode of the latched request.
  logic               sel_ok;
  logic [IDX_W-1:0]   sel_idx;
  logic [CNT_W-1:0]   n_cur;
  logic               full;
  logic               empty;
  logic               wr_en;
  logic               rd_en;
  logic [CNT_W-1:0]   n_nxt;
  logic [STATUS_W-1:0] status_nxt;
  logic [DATA_W-1:0]  data_nxt;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ADDR_W-1:0]  rd_addr;
  logic [CNT_W-1:0]   top_ptr;

  // Work out the outcome of the latched request.
  always_comb begin
    sel_ok     = (int'(sel_r) < NUM_STACKS);
    sel_idx    = IDX_W'(sel_r);
    n_cur      = sel_ok ? cnt_r[sel_idx] : '0;
    full       = (CMP_W'(n_cur) >= CMP_W'(cap_r)) || (n_cur >= CNT_W'(DEPTH));
    empty      = (n_cur == '0);
    top_ptr    = n_cur - CNT_W'(1);
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    n_nxt      = n_cur;
    status_nxt = STS_OK;
    data_nxt   = '0;
    case (op_r)
      OP_PUSH: begin
        if (!sel_ok || full) begin
          status_nxt = STS_FULL;
        end else begin
          wr_en    = 1'b1;
          n_nxt    = n_cur + CNT_W'(1);
          data_nxt = val_r;
        end
      end
      OP_POP, OP_PEEK: begin
        if (!sel_ok || empty) begin
          status_nxt = STS_EMPTY;
        end else begin
          rd_en = 1'b1;
          if (op_r == OP_POP) begin
            n_nxt = top_ptr;
          end
        end
      end
      OP_SIZE: begin
        status_nxt = STS_OK;
      end
      default: begin
        status_nxt = STS_OK;
      end
    endcase
    wr_addr = ADDR_W'(sel_idx) * ADDR_W'(DEPTH) + ADDR_W'(n_cur);
    rd_addr = ADDR_W'(sel_idx) * ADDR_W'(DEPTH) + ADDR_W'(top_ptr);
  end

  assign stat.out_free = !out_valid_r || out_ready;

  // Request latch.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= req_op;
      sel_r <= req_sel;
      val_r <= req_value;
    end
  end

  // Capacity register and per-stack counts.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
      for (int i = 0; i < NUM_STACKS; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      if (cfg_wr) begin
        cap_r <= cfg_cap;
      end
      if (cmd.exec && sel_ok) begin
        cnt_r[sel_idx] <= n_nxt;
      end
    end
  end

  // Element memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[wr_addr] <= val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Result stage valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result stage payload.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_status_r   <= status_nxt;
      out_data_r     <= data_nxt;
      out_count_r    <= COUNT_W'(n_nxt);
      out_from_mem_r <= rd_en;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_from_mem_r ? rd_data_r : out_data_r;
  assign out_count  = out_count_r;

  // The controller never overwrites a result that is still waiting.
  `TSS_ASSERT_NOW(a_exec_slot_free, cmd.exec, !out_valid_r || out_ready)
  // A request to a missing stack reports a zero count.
  `TSS_ASSERT_NEXT(a_missing_zero, cmd.exec && !sel_ok, out_count_r == '0)
  // A store read is only issued for a successful pop or peek.
  `TSS_ASSERT_NEXT(a_read_ok, cmd.exec && rd_en, out_status_r == STS_OK && out_from_mem_r)

endmodule

/* rtl/three_stacks_shared_store_top.sv */
// Top level of the three-stack shared store: stream ports, configuration port,
// controller and datapath. Depends on tss_pkg, tss_ctrl and tss_dp.
//
// Usage
//   Requests arrive on the in_ stream: in_tuser carries the operation and the
//   stack number, in_tdata the word to push. Each request produces exactly one
//   result on the out_ stream: out_tuser carries the status, out_tdata the
//   returned word and the stack's element count after the operation.
//   The capacity register is written through cfg_valid/cfg_data, one
//   transaction per write; cfg_ready is always high.
//   A request is accepted in the idle state and then executed in the execute
//   state against the counts and the element memory, whose read data is
//   registered; the result is valid once the execute step has been taken.
//   No new request is accepted until the current one has executed.
//   A finished result waits in an output register, so the next request is
//   accepted while it is still held; if the receiver stalls, execution of that
//   request waits until the output register frees.
//   Reset clears all counts and the result stage and sets the capacity to
//   256. The element memory is not cleared; an entry is only read after it
//   has been written.
`timescale 1ns / 1ps

module three_stacks_shared_store_top #(
  parameter int DEPTH      = tss_pkg::DEPTH_DEF,
  parameter int NUM_STACKS = tss_pkg::NUM_STACKS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Request stream.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [tss_pkg::VALUE_W-1:0]       in_tdata,    // [31:0] value
  input  logic [tss_pkg::IN_USER_W-1:0]     in_tuser,    // [1:0] op, [3:2] stack_sel
  // Result stream.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [tss_pkg::OUT_TDATA_W-1:0]   out_tdata,   // [31:0] data, [40:32] count
  output logic [tss_pkg::STATUS_W-1:0]      out_tuser,   // [1:0] status
  // Capacity register write channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tss_pkg::CAP_W-1:0]         cfg_data
);
  import tss_pkg::*;

  tss_cmd_t            cmd;
  tss_stat_t           stat;
  logic [DATA_W-1:0]   res_data;
  logic [COUNT_W-1:0]  res_count;

  // The capacity register can be written at any time.
  assign cfg_ready = 1'b1;

  // Controller.
  tss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath.
  tss_dp #(
    .DEPTH      (DEPTH),
    .NUM_STACKS (NUM_STACKS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .req_op     (in_tuser[OP_W-1:0]),
    .req_sel    (in_tuser[OP_W +: SEL_W]),
    .req_value  (in_tdata),
    .cfg_wr     (cfg_valid),
    .cfg_cap    (cfg_data),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_status (out_tuser),
    .out_data   (res_data),
    .out_count  (res_count)
  );

  // Pack the result word, padded to whole bytes.
  assign out_tdata = {{(OUT_TDATA_W - OUT_DATA_RAW_W){1'b0}}, res_count, res_data};

endmodule
